/* rtl/ncs_pkg.sv */
package ncs_pkg;

  // Geometry of the codebook and the sample format
  localparam int VECTOR_LENGTH = 64;
  localparam int MAX_ENTRIES   = 256;
  localparam int SAMPLE_BITS   = 16;

  localparam int POS_W     = $clog2(VECTOR_LENGTH);
  localparam int ENTRY_W   = $clog2(MAX_ENTRIES);
  localparam int CB_ADDR_W = ENTRY_W + POS_W;
  localparam int CNT_W     = 9;
  localparam int DIFF_W    = SAMPLE_BITS + 1;
  localparam int SQ_W      = 2 * SAMPLE_BITS;
  localparam int DIST_W    = 38;

  // Config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ENTRIES = PADDR_W'(0);

  // Input item codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT
  } state_t;

  // Control that travels alongside one element through the distance pipe
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic               fin;
    logic [ENTRY_W-1:0] entry;
  } tag_t;

  // Running winner reported back to the sequencer
  typedef struct packed {
    logic               done;
    logic [ENTRY_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } best_t;

endpackage

/* rtl/ncs_dist_unit.sv */
module ncs_dist_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ncs_pkg::tag_t                          tag,
  input  logic signed [ncs_pkg::SAMPLE_BITS-1:0] query_value,
  input  logic signed [ncs_pkg::SAMPLE_BITS-1:0] code_value,
  output ncs_pkg::best_t                         best
);
  import ncs_pkg::*;

  tag_t                      tag_d;
  tag_t                      tag_s;
  tag_t                      tag_a;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]           sq;
  logic [DIST_W-1:0]         acc;
  logic [ENTRY_W-1:0]        best_index;
  logic [DIST_W-1:0]         win_distance;
  logic                      done;
  logic                      take;

  assign prod = diff * diff;

  // entry 0 always seeds the winner; later entries need a strictly smaller distance
  assign take = tag_a.valid && tag_a.last && ((tag_a.entry == '0) || (acc < win_distance));

  // Tag pipeline and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d <= '0;
      tag_s <= '0;
      tag_a <= '0;
      done  <= 1'b0;
    end else begin
      tag_d <= tag;
      tag_s <= tag_d;
      tag_a <= tag_s;
      done  <= tag_a.valid && tag_a.last && tag_a.fin;
    end
  end

  // Difference, square, accumulate, compare
  always_ff @(posedge clk) begin
    diff <= DIFF_W'(query_value) - DIFF_W'(code_value);
    sq   <= prod[SQ_W-1:0];
    if (tag_s.valid) begin
      acc <= (tag_s.first ? '0 : acc) + DIST_W'(sq);
    end
    if (take) begin
      best_index   <= tag_a.entry;
      win_distance <= acc;
    end
  end

  assign best.done     = done;
  assign best.index    = best_index;
  assign best.distance = win_distance;

endmodule

/* rtl/nearest_codeword_search.sv */
// Codebook write and non-final query transactions: accepted while idle, ready in idle.
// Final query element: starts a search over the configured entries, followed by a
// pipeline drain through the shared subtract/square/accumulate unit.
// Result: 64 output transactions, each read through the single codebook read port.
// No input is taken from the final query element until the last result is taken.
// Reset (rst, synchronous): idle, entry count 256; codebook and query buffer not cleared.
module nearest_codeword_search (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ncs_pkg::PADDR_W-1:0]            paddr,
  input  logic [ncs_pkg::PDATA_W-1:0]            pwdata,
  output logic [ncs_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   func,
  input  logic [ncs_pkg::ENTRY_W-1:0]            entry_index,
  input  logic [ncs_pkg::POS_W-1:0]              element_index,
  input  logic signed [ncs_pkg::SAMPLE_BITS-1:0] element_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ncs_pkg::SAMPLE_BITS-1:0] codeword_value,
  output logic [ncs_pkg::POS_W-1:0]              out_position,
  output logic [ncs_pkg::ENTRY_W-1:0]            best_index,
  output logic [ncs_pkg::DIST_W-1:0]             best_distance,
  output logic                                   last
);
  import ncs_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(VECTOR_LENGTH - 1);

  state_t                          state;
  state_t                          state_next;
  logic [CNT_W-1:0]                codebook_entries;
  logic [ENTRY_W-1:0]              last_ent;
  logic [ENTRY_W-1:0]              srch_entry;
  logic [POS_W-1:0]                srch_pos;
  logic [POS_W-1:0]                emit_pos;
  logic                            in_acc;
  logic                            pos_ok;
  logic                            entry_ok;
  logic                            start;
  logic                            cfg_wr;

  logic signed [SAMPLE_BITS-1:0]   cb_mem [MAX_ENTRIES*VECTOR_LENGTH];
  logic signed [SAMPLE_BITS-1:0]   qb_mem [VECTOR_LENGTH];
  logic [CB_ADDR_W-1:0]            cb_raddr;
  logic [POS_W-1:0]                qb_raddr;
  logic signed [SAMPLE_BITS-1:0]   cb_rdata;
  logic signed [SAMPLE_BITS-1:0]   qb_rdata;

  tag_t                            issue;
  tag_t                            tag_q;
  best_t                           best;

  // Input decode
  assign in_acc   = in_valid && in_ready;
  assign pos_ok   = {1'b0, element_index} < (POS_W+1)'(VECTOR_LENGTH);
  assign entry_ok = {1'b0, entry_index} < (ENTRY_W+1)'(MAX_ENTRIES);
  assign start    = in_acc && pos_ok && (func == FUNC_QUERY) && (element_index == LAST_POS);

  // Config register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codebook_entries <= CNT_W'(MAX_ENTRIES);
    end else if (cfg_wr && (paddr == REG_ENTRIES)) begin
      codebook_entries <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_ENTRIES) begin
      prdata = PDATA_W'(codebook_entries);
    end
  end

  // Highest entry searched; zero counts as one, oversize clamps
  always_comb begin
    if (codebook_entries == '0) begin
      last_ent = '0;
    end else if (codebook_entries > CNT_W'(MAX_ENTRIES)) begin
      last_ent = ENTRY_W'(MAX_ENTRIES - 1);
    end else begin
      last_ent = ENTRY_W'(codebook_entries - CNT_W'(1));
    end
  end

  // Codebook memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && pos_ok && entry_ok && (func == FUNC_WRITE)) begin
      cb_mem[{entry_index, element_index}] <= element_value;
    end
    cb_rdata <= cb_mem[cb_raddr];
  end

  // Query buffer
  always_ff @(posedge clk) begin
    if (in_acc && pos_ok && (func == FUNC_QUERY)) begin
      qb_mem[element_index] <= element_value;
    end
    qb_rdata <= qb_mem[qb_raddr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if ((srch_pos == LAST_POS) && (srch_entry == last_ent)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (best.done) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD:  state_next = ST_EMIT_LD;
      ST_EMIT_LD:  state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_ready) begin
          state_next = (emit_pos == LAST_POS) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    issue       = '0;
    issue.entry = srch_entry;
    cb_raddr    = {srch_entry, srch_pos};
    qb_raddr    = srch_pos;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SEARCH: begin
        issue.valid = 1'b1;
        issue.first = (srch_pos == '0);
        issue.last  = (srch_pos == LAST_POS);
        issue.fin   = (srch_pos == LAST_POS) && (srch_entry == last_ent);
      end
      ST_EMIT_RD:  cb_raddr = {best.index, emit_pos};
      ST_EMIT_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  // Search and emit counters, issue tag aligned with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      srch_entry <= '0;
      srch_pos   <= '0;
      emit_pos   <= '0;
      tag_q      <= '0;
    end else begin
      tag_q <= issue;
      case (state)
        ST_IDLE: begin
          srch_entry <= '0;
          srch_pos   <= '0;
          emit_pos   <= '0;
        end
        ST_SEARCH: begin
          srch_pos <= srch_pos + POS_W'(1);
          if (srch_pos == LAST_POS) begin
            srch_entry <= srch_entry + ENTRY_W'(1);
          end
        end
        ST_EMIT_OUT: begin
          if (out_ready) begin
            emit_pos <= emit_pos + POS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD) begin
      codeword_value <= cb_rdata;
      out_position   <= emit_pos;
      last           <= (emit_pos == LAST_POS);
    end
  end

  assign best_index    = best.index;
  assign best_distance = best.distance;

  // Shared distance unit
  ncs_dist_unit u_dist (
    .clk         (clk),
    .rst         (rst),
    .tag         (tag_q),
    .query_value (qb_rdata),
    .code_value  (cb_rdata),
    .best        (best)
  );

  // Checks
  a_no_overlap : assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open at once");

  a_done_in_drain : assert property (@(posedge clk) disable iff (rst)
    best.done |-> (state == ST_DRAIN))
    else $error("search completion outside drain");

  a_best_in_range : assert property (@(posedge clk) disable iff (rst)
    best.done |-> (best.index <= last_ent))
    else $error("winner beyond searched entries");

  a_idle_after_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("not idle after final result");

endmodule

/* tb/nearest_codeword_search_test.sv */
`timescale 1ns / 1ps

module nearest_codeword_search_test;
  import ncs_pkg::*;

  localparam int CYCLE_LIMIT   = 5000000;
  localparam int RANDOM_ITEMS  = 80;
  localparam int RANDOM_SPAN   = 4;
  localparam int SETTLE_CYCLES = 10;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef enum int {VAL_FULL, VAL_RAIL, VAL_NEAR_ZERO} value_mode_t;

  // one emitted codeword element
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [POS_W-1:0]              position;
    logic [ENTRY_W-1:0]            index;
    logic [DIST_W-1:0]             distance;
    logic                          last;
  } codeword_elem_t;

  logic                          clk;
  logic                          rst           = 1'b1;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [PADDR_W-1:0]            paddr         = REG_ENTRIES;
  logic [PDATA_W-1:0]            pwdata        = '0;
  logic [PDATA_W-1:0]            prdata;
  logic                          pready;
  logic                          in_valid      = 1'b0;
  logic                          in_ready;
  logic                          func          = FUNC_WRITE;
  logic [ENTRY_W-1:0]            entry_index   = '0;
  logic [POS_W-1:0]              element_index = '0;
  logic signed [SAMPLE_BITS-1:0] element_value = '0;
  logic                          out_valid;
  logic                          out_ready     = 1'b1;
  logic signed [SAMPLE_BITS-1:0] codeword_value;
  logic [POS_W-1:0]              out_position;
  logic [ENTRY_W-1:0]            best_index;
  logic [DIST_W-1:0]             best_distance;
  logic                          last;

  // mirror of the block's storage and setting
  logic signed [SAMPLE_BITS-1:0] cb_mirror [MAX_ENTRIES][VECTOR_LENGTH];
  bit [VECTOR_LENGTH-1:0]        cb_written [MAX_ENTRIES];
  logic signed [SAMPLE_BITS-1:0] query_mirror [VECTOR_LENGTH];
  logic [CNT_W-1:0]              entries_cfg = 9'd256;

  codeword_elem_t expected_words [$];
  codeword_elem_t want_word;
  int             mismatches  = 0;
  int unsigned    sent_items  = 0;
  int unsigned    cycle_count = 0;
  bit             idle_on     = 1'b0;
  bit             stall_on    = 1'b0;

  nearest_codeword_search dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .entry_index   (entry_index),
    .element_index (element_index),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .codeword_value(codeword_value),
    .out_position  (out_position),
    .best_index    (best_index),
    .best_distance (best_distance),
    .last          (last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int unsigned searched_entries(input logic [CNT_W-1:0] cfg);
    if (cfg == 0) return 1;
    if (cfg > MAX_ENTRIES) return MAX_ENTRIES;
    return cfg;
  endfunction

  function automatic longint unsigned sq_distance(input int unsigned entry);
    longint unsigned acc;
    longint          diff;
    acc = 0;
    for (int i = 0; i < VECTOR_LENGTH; i++) begin
      diff = longint'(query_mirror[i]) - longint'(cb_mirror[entry][i]);
      acc += longint'(diff * diff);
    end
    return acc;
  endfunction

  // update the mirror with one accepted transaction, queue the codeword it yields
  task automatic predict_nearest(input logic f, input logic [ENTRY_W-1:0] ent,
                                 input logic [POS_W-1:0] pos,
                                 input logic signed [SAMPLE_BITS-1:0] val);
    int unsigned     count;
    int unsigned     best;
    longint unsigned best_d;
    longint unsigned d;
    codeword_elem_t  w;
    if (f == FUNC_WRITE) begin
      cb_mirror[ent][pos] = val;
      cb_written[ent][pos] = 1'b1;
    end else begin
      query_mirror[pos] = val;
      if (pos == VECTOR_LENGTH - 1) begin
        count = searched_entries(entries_cfg);
        best = 0;
        best_d = sq_distance(0);
        for (int unsigned j = 1; j < count; j++) begin
          d = sq_distance(j);
          // strict compare keeps the lower index on a tie
          if (d < best_d) begin
            best_d = d;
            best = j;
          end
        end
        for (int k = 0; k < VECTOR_LENGTH; k++) begin
          w.value    = cb_mirror[best][k];
          w.position = POS_W'(k);
          w.index    = ENTRY_W'(best);
          w.distance = DIST_W'(best_d);
          w.last     = (k == VECTOR_LENGTH - 1);
          expected_words.push_back(w);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string what, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result with nothing expected: position %0d index %0d value %0d",
                 $time, out_position, best_index, codeword_value);
        mismatches++;
      end else begin
        want_word = expected_words.pop_front();
        check_field("codeword_value", want_word.value, codeword_value);
        check_field("out_position", want_word.position, out_position);
        check_field("best_index", want_word.index, best_index);
        check_field("best_distance", want_word.distance, best_distance);
        check_field("last", want_word.last, last);
      end
    end
  end

  // result side back-pressure: random stall bursts and calm stretches
  always begin
    @(negedge clk);
    if (stall_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
      out_ready <= 1'b1;
    end else if (stall_on && $urandom_range(0, 31) == 0) begin
      repeat ($urandom_range(20, 120)) @(negedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  // one input transaction; called and returns at a falling edge
  task automatic send_item(input logic f, input logic [ENTRY_W-1:0] ent,
                           input logic [POS_W-1:0] pos,
                           input logic signed [SAMPLE_BITS-1:0] val);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    entry_index   <= ent;
    element_index <= pos;
    element_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_nearest(f, ent, pos, val);
    sent_items++;
    @(negedge clk);
  endtask

  // drop valid, wait for every expected result, then let the block go idle
  task automatic settle;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_read(output logic [PDATA_W-1:0] got);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_ENTRIES;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write the entry count with junk above the field, then read it back
  task automatic set_entries(input logic [CNT_W-1:0] v);
    logic [PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ENTRIES;
    pwdata  <= (PDATA_W'($urandom()) << CNT_W) | PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    entries_cfg = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    apb_read(got);
    check_field("codebook_entries readback", v, got);
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic signed [SAMPLE_BITS-1:0] pick_value(input value_mode_t mode);
    case (mode)
      VAL_RAIL: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return '0;
          3: return '1;
          default: return SAMPLE_BITS'(1);
        endcase
      end
      VAL_NEAR_ZERO: return SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // lean queries sit a few LSBs away from one codeword
  function automatic logic signed [SAMPLE_BITS-1:0] query_value(
      input bit lean, input int unsigned near, input int unsigned pos,
      input value_mode_t mode);
    int t;
    if (!lean) return pick_value(mode);
    t = int'(cb_mirror[near][pos]) + int'($urandom_range(0, 6)) - 3;
    if (t < int'(SAMPLE_MIN)) t = int'(SAMPLE_MIN);
    if (t > int'(SAMPLE_MAX)) t = int'(SAMPLE_MAX);
    return SAMPLE_BITS'(t);
  endfunction

  // at least half the writes land inside the searched range
  function automatic logic [ENTRY_W-1:0] pick_entry(input int unsigned count);
    if ($urandom_range(0, 1) == 0) return ENTRY_W'($urandom_range(0, count - 1));
    return ENTRY_W'($urandom_range(0, MAX_ENTRIES - 1));
  endfunction

  // all 64 elements of one vector set to a constant
  task automatic fill_const(input logic f, input int unsigned ent,
                            input logic signed [SAMPLE_BITS-1:0] v);
    for (int p = 0; p < VECTOR_LENGTH; p++)
      send_item(f, ENTRY_W'(ent), POS_W'(p), v);
  endtask

  // make sure every codeword a search can touch has been written in full
  task automatic ensure_filled(input int unsigned count);
    value_mode_t mode;
    for (int unsigned e = 0; e < count; e++) begin
      if (!(&cb_written[e])) begin
        mode = value_mode_t'($urandom_range(0, 2));
        for (int p = 0; p < VECTOR_LENGTH; p++)
          send_item(FUNC_WRITE, ENTRY_W'(e), POS_W'(p), pick_value(mode));
      end
    end
  endtask

  // codebook updates, an occasional duplicated codeword, then a query ending in a search
  task automatic random_round(input int unsigned count, input value_mode_t mode);
    bit               lean;
    int unsigned      near;
    int unsigned      src;
    logic [POS_W-1:0] at;
    repeat ($urandom_range(0, 3))
      send_item(FUNC_WRITE, pick_entry(count), POS_W'($urandom()), pick_value(mode));
    // identical codewords force distance ties
    if (count >= 2 && $urandom_range(0, 4) == 0) begin
      src  = $urandom_range(0, count - 2);
      near = $urandom_range(src + 1, count - 1);
      for (int p = 0; p < VECTOR_LENGTH; p++)
        send_item(FUNC_WRITE, ENTRY_W'(near), POS_W'(p), cb_mirror[src][p]);
    end
    lean = ($urandom_range(0, 3) == 0);
    near = $urandom_range(0, count - 1);
    if ($urandom_range(0, 5) == 0) begin
      // whole query in order, writes mixed in
      for (int p = 0; p < VECTOR_LENGTH - 1; p++) begin
        if ($urandom_range(0, 15) == 0)
          send_item(FUNC_WRITE, pick_entry(count), POS_W'($urandom()), pick_value(mode));
        send_item(FUNC_QUERY, ENTRY_W'($urandom()), POS_W'(p),
                  query_value(lean, near, p, mode));
      end
    end else begin
      // partial update, the rest of the buffered query is reused
      repeat ($urandom_range(0, 8)) begin
        at = POS_W'($urandom_range(0, VECTOR_LENGTH - 2));
        send_item(FUNC_QUERY, ENTRY_W'($urandom()), at, query_value(lean, near, at, mode));
      end
    end
    send_item(FUNC_QUERY, ENTRY_W'($urandom()), POS_W'(VECTOR_LENGTH - 1),
              query_value(lean, near, VECTOR_LENGTH - 1, mode));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_register;
    logic [PDATA_W-1:0] got;
    apb_read(got);
    check_field("codebook_entries after reset", 256, got);
    @(negedge clk);
  endtask

  task automatic test_corner_codewords;
    set_entries(9'd4);
    fill_const(FUNC_WRITE, 0, SAMPLE_MIN);
    fill_const(FUNC_WRITE, 1, SAMPLE_MAX);
    fill_const(FUNC_WRITE, 2, '0);
    fill_const(FUNC_WRITE, 3, '0);
    // zero query: entries 2 and 3 tie at distance zero, lower index wins
    fill_const(FUNC_QUERY, $urandom_range(0, 255), '0);
    // final element alone, the other 63 stay buffered
    send_item(FUNC_QUERY, 8'hFF, POS_W'(VECTOR_LENGTH - 1), SAMPLE_MAX);
    // exact hit on the positive rail codeword
    fill_const(FUNC_QUERY, 8'hA5, SAMPLE_MAX);
    // one entry searched: largest possible distance
    settle();
    set_entries(9'd1);
    send_item(FUNC_QUERY, 8'h00, POS_W'(VECTOR_LENGTH - 1), SAMPLE_MAX);
    // zero count behaves as one entry
    settle();
    set_entries(9'd0);
    send_item(FUNC_QUERY, 8'h5A, POS_W'(VECTOR_LENGTH - 1), SAMPLE_MIN);
    settle();
  endtask

  task automatic test_random_traffic;
    int unsigned start;
    idle_on  = 1'b1;
    stall_on = 1'b1;
    ensure_filled(RANDOM_SPAN);
    start = sent_items;
    while (sent_items - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        if ($urandom_range(0, 9) == 0)
          set_entries('0);
        else
          set_entries(CNT_W'($urandom_range(1, RANDOM_SPAN)));
      end
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      random_round(searched_entries(entries_cfg), value_mode_t'($urandom_range(0, 2)));
    end
    settle();
  endtask

  // closing traffic over the widest random span, no idling from here on
  task automatic test_calm_tail;
    idle_on  = 1'b0;
    stall_on = 1'b0;
    settle();
    set_entries(CNT_W'(RANDOM_SPAN));
    repeat (3)
      random_round(RANDOM_SPAN, value_mode_t'($urandom_range(0, 2)));
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_register();
    test_corner_codewords();
    test_random_traffic();
    test_calm_tail();
    settle();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
